>>> rtl/core/rfsc_pkg.sv
// ----------------------------------------------------------------------------
// rfsc_pkg
// Shared constants, status codes and the message length table for the
// receiver frame synchronizer.
// ----------------------------------------------------------------------------
package rfsc_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned POS_W      = 9;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned LONGEST_FRAME_DEF = 379;

  localparam logic [BYTE_W-1:0] SYNC_RESET = 8'h8B;

  localparam logic [STATUS_W-1:0] ST_DISCARD  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_IN_FRAME = 2'd1;
  localparam logic [STATUS_W-1:0] ST_GOOD     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_CSUM_ERR = 2'd3;

  // Total frame length per message id, sync and checksum bytes included.
  // Zero marks an unknown id.
  function automatic logic [POS_W-1:0] frame_len_lookup(input logic [BYTE_W-1:0] id);
    logic [POS_W-1:0] len;
    len = '0;
    case (id)
      8'h08:   len = 9'd379;
      8'h02:   len = 9'd48;
      8'h03:   len = 9'd40;
      8'h06:   len = 9'd21;
      8'h07:   len = 9'd22;
      8'h20:   len = 9'd227;
      8'h22:   len = 9'd17;
      8'h23:   len = 9'd67;
      8'h24:   len = 9'd68;
      8'h25:   len = 9'd39;
      8'h26:   len = 9'd32;
      8'h27:   len = 9'd98;
      default: len = '0;
    endcase
    return len;
  endfunction

endpackage

>>> rtl/core/receiver_frame_sync_checksum.sv
// ----------------------------------------------------------------------------
// receiver_frame_sync_checksum
// Byte-stream framer: sync byte hunt, id-based length lookup and 8-bit
// sum checksum check, one status report per received byte.
// ----------------------------------------------------------------------------
// Takes one byte per cycle and returns one report per byte in the cycle
// after acceptance; a new byte is accepted every cycle as long as the report
// register is empty or being drained. Frame length comes from a fixed id
// table, and the final byte of a frame is compared against the modulo-256
// sum of all bytes from the id up to the byte before it. sync_value may be
// changed through cfg_wr_en/cfg_wr_data only while no transaction is in flight.
module receiver_frame_sync_checksum #(
  parameter int unsigned LONGEST_FRAME = rfsc_pkg::LONGEST_FRAME_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [rfsc_pkg::BYTE_W-1:0]    cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rfsc_pkg::BYTE_W-1:0]    in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rfsc_pkg::STATUS_W-1:0]  out_status,
  output logic [rfsc_pkg::BYTE_W-1:0]    out_byte_out,
  output logic [rfsc_pkg::POS_W-1:0]     out_position,
  output logic [rfsc_pkg::BYTE_W-1:0]    out_message_id
);
  import rfsc_pkg::*;

  localparam logic [POS_W:0] LEN_LIMIT = (POS_W+1)'(LONGEST_FRAME);

  logic [BYTE_W-1:0]   sync_value_r;
  logic [POS_W-1:0]    byte_count_r, byte_count_nxt;
  logic [BYTE_W-1:0]   frame_id_r, frame_id_nxt;
  logic [POS_W-1:0]    frame_length_r, frame_length_nxt;
  logic [BYTE_W-1:0]   running_sum_r, running_sum_nxt;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [BYTE_W-1:0]   out_byte_r;
  logic [POS_W-1:0]    out_position_r, out_position_nxt;
  logic [BYTE_W-1:0]   out_id_r, out_id_nxt;

  logic                in_fire;
  logic [POS_W-1:0]    tbl_len;
  logic [POS_W-1:0]    id_len;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign tbl_len = frame_len_lookup(in_rx_byte);
  assign id_len  = ({1'b0, tbl_len} > LEN_LIMIT) ? '0 : tbl_len;

  always_comb begin
    byte_count_nxt   = byte_count_r;
    frame_id_nxt     = frame_id_r;
    frame_length_nxt = frame_length_r;
    running_sum_nxt  = running_sum_r;
    out_status_nxt   = ST_DISCARD;
    out_position_nxt = '0;
    out_id_nxt       = '0;
    if (byte_count_r == '0) begin
      if (in_rx_byte == sync_value_r) begin
        byte_count_nxt = POS_W'(1);
        out_status_nxt = ST_IN_FRAME;
      end
    end else if (byte_count_r == POS_W'(1)) begin
      out_position_nxt = POS_W'(1);
      if (id_len == '0) begin
        byte_count_nxt   = '0;
        frame_id_nxt     = '0;
        frame_length_nxt = '0;
        running_sum_nxt  = '0;
      end else begin
        byte_count_nxt   = POS_W'(2);
        frame_id_nxt     = in_rx_byte;
        frame_length_nxt = id_len;
        running_sum_nxt  = in_rx_byte;
        out_status_nxt   = ST_IN_FRAME;
        out_id_nxt       = in_rx_byte;
      end
    end else if (frame_length_r == '0 || byte_count_r >= frame_length_r) begin
      byte_count_nxt   = '0;
      frame_id_nxt     = '0;
      frame_length_nxt = '0;
      running_sum_nxt  = '0;
    end else if (byte_count_r == frame_length_r - POS_W'(1)) begin
      out_status_nxt   = (in_rx_byte == running_sum_r) ? ST_GOOD : ST_CSUM_ERR;
      out_position_nxt = byte_count_r;
      out_id_nxt       = frame_id_r;
      byte_count_nxt   = '0;
      frame_id_nxt     = '0;
      frame_length_nxt = '0;
      running_sum_nxt  = '0;
    end else begin
      running_sum_nxt  = running_sum_r + in_rx_byte;
      byte_count_nxt   = byte_count_r + POS_W'(1);
      out_status_nxt   = ST_IN_FRAME;
      out_position_nxt = byte_count_r;
      out_id_nxt       = frame_id_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_value_r   <= SYNC_RESET;
      byte_count_r   <= '0;
      frame_id_r     <= '0;
      frame_length_r <= '0;
      running_sum_r  <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        sync_value_r <= cfg_wr_data;
      end
      if (in_fire) begin
        byte_count_r   <= byte_count_nxt;
        frame_id_r     <= frame_id_nxt;
        frame_length_r <= frame_length_nxt;
        running_sum_r  <= running_sum_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_status_r   <= out_status_nxt;
      out_byte_r     <= in_rx_byte;
      out_position_r <= out_position_nxt;
      out_id_r       <= out_id_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_byte_out   = out_byte_r;
  assign out_position   = out_position_r;
  assign out_message_id = out_id_r;

`ifndef SYNTHESIS
  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted transaction produced no result");

  a_count_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_count_r > POS_W'(1)) |-> (frame_length_r != '0 && byte_count_r < frame_length_r))
    else $error("frame counter outside frame length");

  a_len_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, frame_length_r} <= LEN_LIMIT))
    else $error("frame length above limit");

  a_end_returns_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && byte_count_r > POS_W'(1) && byte_count_r == frame_length_r - POS_W'(1))
    |=> (byte_count_r == '0 && running_sum_r == '0))
    else $error("framer not hunting after frame end");
`endif

endmodule
